[rtl/ssqe_pkg.sv]
package ssqe_pkg;

    typedef struct packed {
        logic        cmd;
        logic [31:0] from_x;
        logic [31:0] from_y;
        logic [31:0] to_x;
        logic [31:0] to_y;
    } t_in_word;

    typedef struct packed {
        logic        kind;
        logic [31:0] vertex_x;
        logic [31:0] vertex_y;
        logic [15:0] index_value;
        logic        last;
    } t_out_word;

    typedef enum logic [2:0] {
        S_IDLE,
        S_NORM,
        S_SQRT,
        S_DIV,
        S_EMIT
    } t_state;

    localparam logic       CMD_FLUSH    = 1'b1;
    localparam logic       KIND_VERTEX  = 1'b0;
    localparam logic       KIND_INDEX   = 1'b1;
    localparam logic [15:0] WIDTH_MIN   = 16'd256;
    localparam logic [15:0] WIDTH_RESET = 16'd256;
    localparam logic [1:0]  REG_WIDTH   = 2'd0;

endpackage

[rtl/ssqe_sqrt.sv]
// Bit-serial integer square root: two radicand bits per cycle, one root bit.
module ssqe_sqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_n,
    output logic        o_done,
    output logic [31:0] o_root
);
    logic [63:0] r_n;
    logic [33:0] r_rem;
    logic [31:0] r_root;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [33:0] w_trial;
    logic [33:0] w_sub;

    assign w_trial = {r_rem[31:0], r_n[63:62]};
    assign w_sub   = {r_root, 2'b01};

    // advance one root digit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
            r_n    <= i_n;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_n <= {r_n[61:0], 2'b00};
            if (w_trial >= w_sub) begin
                r_rem  <= w_trial - w_sub;
                r_root <= {r_root[30:0], 1'b1};
            end else begin
                r_rem  <= w_trial;
                r_root <= {r_root[30:0], 1'b0};
            end
            r_cnt <= r_cnt + 6'd1;
            if (r_cnt == 6'd31) r_busy <= 1'b0;
        end
    end

    // flag the cycle after the last digit, when the root is complete
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_done <= 1'b0;
        else r_done <= r_busy && !i_start && (r_cnt == 6'd31);
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule

[rtl/ssqe_div.sv]
// Restoring divider, one quotient bit per cycle, 48-bit dividend.
module ssqe_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [47:0] i_num,
    input  logic [32:0] i_den,
    output logic        o_done,
    output logic [47:0] o_quo
);
    logic [47:0] r_q;
    logic [33:0] r_rem;
    logic [32:0] r_den;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [33:0] w_trial;

    assign w_trial = {r_rem[32:0], r_q[47]};

    // shift in one dividend bit, subtract when it fits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
            r_q    <= i_num;
            r_rem  <= '0;
            r_den  <= i_den;
        end else if (r_busy) begin
            if (w_trial >= {1'b0, r_den}) begin
                r_rem <= w_trial - {1'b0, r_den};
                r_q   <= {r_q[46:0], 1'b1};
            end else begin
                r_rem <= w_trial;
                r_q   <= {r_q[46:0], 1'b0};
            end
            r_cnt <= r_cnt + 6'd1;
            if (r_cnt == 6'd47) r_busy <= 1'b0;
        end
    end

    // flag the cycle after the last quotient bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_done <= 1'b0;
        else r_done <= r_busy && !i_start && (r_cnt == 6'd47);
    end

    assign o_done = r_done;
    assign o_quo  = r_q;
endmodule

[rtl/stroke_segment_quad_expander_core.sv]
// Expands each line segment into four offset vertices and six indices (ten
// words, the last flagged). A segment is accepted, then its magnitudes are
// shifted to normalize them, a bit-serial square root runs, two 48-bit
// serial divisions share one divider, then ten output words are emitted. A
// zero-length segment skips the square root and divisions. A flush word
// emits nothing. The input is stalled while a segment is in progress.
module stroke_segment_quad_expander_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  ssqe_pkg::t_in_word    i_data,
    output logic                  o_valid,
    input  logic                  i_stall,
    output ssqe_pkg::t_out_word   o_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [1:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);
    import ssqe_pkg::*;

    t_state      r_state, n_state;
    logic [15:0] r_width, r_count;
    logic [31:0] r_fx, r_fy, r_tx, r_ty;
    logic        r_ndx, r_ndy, r_zero;
    logic [32:0] r_ax, r_ay;
    logic [31:0] r_mag;
    logic        r_phase;
    logic [47:0] r_mx;
    logic [3:0]  r_k;
    logic [47:0] r_my;
    logic [32:0] w_dx, w_dy, w_m;
    logic        w_acc;
    logic [15:0] w_w;
    logic        w_sq_start, w_sq_done, w_dv_start, w_dv_done;
    logic [31:0] w_root;
    logic [47:0] w_quo;
    logic [31:0] w_sx, w_sy, w_bx, w_by;
    logic [15:0] w_idx;
    logic [63:0] w_sum;
    logic [63:0] w_sq2;

    // config port
    assign pready = 1'b1;
    assign prdata = {16'd0, r_width};
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_width <= WIDTH_RESET;
        else if (psel && penable && pwrite && paddr == REG_WIDTH)
            r_width <= pwdata[15:0];
    end

    assign w_w   = (r_width < WIDTH_MIN) ? WIDTH_MIN : r_width;
    assign w_dx  = {i_data.to_x[31], i_data.to_x} - {i_data.from_x[31], i_data.from_x};
    assign w_dy  = {i_data.to_y[31], i_data.to_y} - {i_data.from_y[31], i_data.from_y};
    assign w_m   = (r_ax > r_ay) ? r_ax : r_ay;
    assign w_acc = i_valid && !o_stall;
    assign o_stall = (r_state != S_IDLE);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_acc && i_data.cmd != CMD_FLUSH) n_state = S_NORM;
            S_NORM: if (r_zero) n_state = S_EMIT;
                    else if (w_m[32:30] == 3'b001) n_state = S_SQRT;
            S_SQRT: if (w_sq_done) n_state = S_DIV;
            S_DIV:  if (w_dv_done && r_phase) n_state = S_EMIT;
            S_EMIT: if (!i_stall && r_k == 4'd9) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // unit controls
    always_comb begin
        w_sq_start = (r_state == S_NORM) && !r_zero && (w_m[32:30] == 3'b001);
        w_dv_start = ((r_state == S_SQRT) && w_sq_done)
                  || ((r_state == S_DIV) && w_dv_done && !r_phase);
    end

    // square input: both below 2^31 here
    assign w_sum = {32'd0, r_ax[31:0]} * {32'd0, r_ax[31:0]};

    // radicand from the normalized magnitudes
    assign w_sq2 = w_sum + {32'd0, r_ay[31:0]} * {32'd0, r_ay[31:0]};

    logic [47:0] w_dnum;
    assign w_dnum = ((r_state == S_SQRT) ? ({16'd0, r_ax[31:0]} * {32'd0, w_w})
                                         : ({16'd0, r_ay[31:0]} * {32'd0, w_w}))
                  + {16'd0, (r_state == S_SQRT) ? w_root : r_mag};

    ssqe_sqrt u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_sq_start),
        .i_n(w_sq2), .o_done(w_sq_done), .o_root(w_root)
    );
    ssqe_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_dv_start),
        .i_num(w_dnum),
        .i_den((r_state == S_SQRT) ? {w_root, 1'b0} : {r_mag, 1'b0}),
        .o_done(w_dv_done), .o_quo(w_quo)
    );

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_k     <= '0;
            r_phase <= 1'b0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_IDLE: begin
                    if (w_acc && i_data.cmd == CMD_FLUSH) r_count <= '0;
                    r_fx <= i_data.from_x; r_fy <= i_data.from_y;
                    r_tx <= i_data.to_x;   r_ty <= i_data.to_y;
                    r_ndx <= w_dx[32]; r_ndy <= w_dy[32];
                    r_ax <= w_dx[32] ? -w_dx : w_dx;
                    r_ay <= w_dy[32] ? -w_dy : w_dy;
                    r_zero <= (w_dx == '0) && (w_dy == '0);
                    r_mx <= '0; r_my <= '0; r_k <= '0; r_phase <= 1'b0;
                end
                S_NORM: begin
                    if (!r_zero) begin
                        if (w_m[32:31] != 2'b00) begin
                            r_ax <= r_ax >> 1; r_ay <= r_ay >> 1;
                        end else if (!w_m[30]) begin
                            r_ax <= r_ax << 1; r_ay <= r_ay << 1;
                        end
                    end
                end
                S_SQRT: if (w_sq_done) r_mag <= w_root;
                S_DIV: if (w_dv_done) begin
                    if (!r_phase) begin r_my <= w_quo; r_phase <= 1'b1; end
                    else r_mx <= w_quo;
                end
                S_EMIT: if (!i_stall) begin
                    r_k <= r_k + 4'd1;
                    if (r_k == 4'd9) r_count <= r_count + 16'd4;
                end
                default: ;
            endcase
        end
    end

    // output word
    assign w_sx = r_ndy ? (32'd0 - r_mx[31:0]) : r_mx[31:0];
    assign w_sy = r_ndx ? r_my[31:0] : (32'd0 - r_my[31:0]);
    assign w_bx = (r_k < 4'd2) ? r_fx : r_tx;
    assign w_by = (r_k < 4'd2) ? r_fy : r_ty;
    always_comb begin
        unique case (r_k)
            4'd4: w_idx = r_count;
            4'd5, 4'd7: w_idx = r_count + 16'd1;
            4'd6, 4'd8: w_idx = r_count + 16'd2;
            4'd9: w_idx = r_count + 16'd3;
            default: w_idx = '0;
        endcase
    end
    assign o_valid = (r_state == S_EMIT);
    always_comb begin
        o_data.last = (r_k == 4'd9);
        o_data.index_value = w_idx;
        if (r_k < 4'd4) begin
            o_data.kind = KIND_VERTEX;
            o_data.vertex_x = r_k[0] ? (w_bx - w_sx) : (w_bx + w_sx);
            o_data.vertex_y = r_k[0] ? (w_by - w_sy) : (w_by + w_sy);
        end else begin
            o_data.kind = KIND_INDEX;
            o_data.vertex_x = '0;
            o_data.vertex_y = '0;
        end
    end
endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps

module tb;
    import ssqe_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    t_in_word    i_data;
    logic        o_valid;
    logic        i_stall;
    t_out_word   o_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    stroke_segment_quad_expander_core dut (.*);

    // model state
    logic [15:0] width_q;
    logic [15:0] vcount_q = '0;

    t_in_word  seg_queue[$];
    t_out_word quad_queue[$];
    int        fail_count;
    int        in_gap;
    int        out_gap;
    bit        in_taken;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic logic [63:0] isqrt(logic [63:0] n);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // expand one accepted segment into its expected quad words; a flush resets the vertex count
    task automatic expand_segment(t_in_word w);
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic [63:0] ax, ay, m, mag, mx, my, wd;
        logic [31:0] sx, sy;
        t_out_word o;
        logic [15:0] ofs[6];
        if (w.cmd == CMD_FLUSH) begin
            vcount_q = 0;
            return;
        end
        dx = $signed({w.to_x[31], w.to_x}) - $signed({w.from_x[31], w.from_x});
        dy = $signed({w.to_y[31], w.to_y}) - $signed({w.from_y[31], w.from_y});
        ax = dx < 0 ? 64'(-dx) : 64'(dx);
        ay = dy < 0 ? 64'(-dy) : 64'(dy);
        wd = (width_q < WIDTH_MIN) ? 64'(WIDTH_MIN) : 64'(width_q);
        m = ax > ay ? ax : ay;
        mx = 0;
        my = 0;
        if (m != 0) begin
            while (m < (64'd1 << 30)) begin
                ax = ax << 1;
                ay = ay << 1;
                m = m << 1;
            end
            if (m >= (64'd1 << 31)) begin
                ax = ax >> 1;
                ay = ay >> 1;
            end
            mag = isqrt(ax * ax + ay * ay);
            my = (ax * wd + mag) / (2 * mag);
            mx = (ay * wd + mag) / (2 * mag);
        end
        sx = dy < 0 ? -mx[31:0] : mx[31:0];
        sy = dx < 0 ? my[31:0] : -my[31:0];
        o = '0;
        o.kind = KIND_VERTEX;
        o.vertex_x = w.from_x + sx; o.vertex_y = w.from_y + sy; quad_queue.push_back(o);
        o.vertex_x = w.from_x - sx; o.vertex_y = w.from_y - sy; quad_queue.push_back(o);
        o.vertex_x = w.to_x + sx;   o.vertex_y = w.to_y + sy;   quad_queue.push_back(o);
        o.vertex_x = w.to_x - sx;   o.vertex_y = w.to_y - sy;   quad_queue.push_back(o);
        ofs = '{0, 1, 2, 1, 2, 3};
        for (int k = 0; k < 6; k++) begin
            o = '0;
            o.kind = KIND_INDEX;
            o.index_value = vcount_q + ofs[k];
            o.last = (k == 5);
            quad_queue.push_back(o);
        end
        vcount_q = vcount_q + 16'd4;
    endtask

    // driver: present queued words with random gaps
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_data <= '0;
        end else if (i_valid && !in_taken) begin
            // hold the stalled word
        end else if (in_gap > 0) begin
            in_gap <= in_gap - 1;
            i_valid <= 1'b0;
        end else if (seg_queue.size() > 0) begin
            i_data <= seg_queue.pop_front();
            i_valid <= 1'b1;
            in_gap <= $urandom_range(0, 6);
        end else begin
            i_valid <= 1'b0;
        end
    end

    // receiver stall
    always @(negedge i_clk) begin
        if (out_gap > 0) begin
            out_gap <= out_gap - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
            if (o_valid) out_gap <= $urandom_range(0, 6);
        end
    end

    // monitor: predict on input accept, check on output accept
    always @(posedge i_clk) begin
        t_out_word e;
        in_taken <= i_rst_n && i_valid && !o_stall;
        if (i_rst_n && i_valid && !o_stall) expand_segment(i_data);
        if (i_rst_n && o_valid && !i_stall) begin
            if (quad_queue.size() == 0) begin
                $error("unexpected word %h", o_data);
                fail_count++;
            end else begin
                e = quad_queue.pop_front();
                if (o_data.kind !== e.kind) begin
                    $error("kind exp %h got %h", e.kind, o_data.kind); fail_count++;
                end
                if (o_data.vertex_x !== e.vertex_x) begin
                    $error("vertex_x exp %h got %h", e.vertex_x, o_data.vertex_x);
                    fail_count++;
                end
                if (o_data.vertex_y !== e.vertex_y) begin
                    $error("vertex_y exp %h got %h", e.vertex_y, o_data.vertex_y);
                    fail_count++;
                end
                if (o_data.index_value !== e.index_value) begin
                    $error("index_value exp %h got %h", e.index_value, o_data.index_value);
                    fail_count++;
                end
                if (o_data.last !== e.last) begin
                    $error("last exp %h got %h", e.last, o_data.last); fail_count++;
                end
            end
        end
    end

    task automatic apb_write(logic [1:0] addr, logic [31:0] val);
        @(negedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr == REG_WIDTH) width_q = val[15:0];
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return $urandom_range(0, 4095) - 2048;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_in_word make_seg(logic c, logic [31:0] fx, logic [31:0] fy,
                                          logic [31:0] tx, logic [31:0] ty);
        t_in_word w;
        w.cmd = c; w.from_x = fx; w.from_y = fy; w.to_x = tx; w.to_y = ty;
        return w;
    endfunction

    task automatic drain();
        wait (seg_queue.size() == 0 && !i_valid);
        wait (quad_queue.size() == 0);
        repeat (200) @(posedge i_clk);
    endtask

    initial begin
        logic [15:0] widths[6];
        logic [31:0] fx, fy;
        i_rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        width_q = WIDTH_RESET;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: extremes, zero length, flush, axis-aligned
        seg_queue.push_back(make_seg(0, 0, 0, 0, 0));
        seg_queue.push_back(make_seg(0, 0, 0, 32'h100, 0));
        seg_queue.push_back(make_seg(0, 0, 0, 0, 32'h100));
        seg_queue.push_back(make_seg(0, 32'h100, 0, 0, 0));
        seg_queue.push_back(make_seg(0, 0, 32'h100, 0, 0));
        seg_queue.push_back(make_seg(0, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF));
        seg_queue.push_back(make_seg(0, 32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h7FFFFFFF));
        seg_queue.push_back(make_seg(0, 32'hFFFFFFFF, 32'hFFFFFFFF, 0, 0));
        seg_queue.push_back(make_seg(0, 0, 0, 1, 1));
        seg_queue.push_back(make_seg(1, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF));
        seg_queue.push_back(make_seg(0, 5, 7, 5, 7));
        drain();

        // width sweep, extremes included, plus ignored register addresses
        widths = '{16'd0, 16'd255, 16'hFFFF, 16'd256, 16'd1000, 16'h0000};
        apb_write(2'd1, 32'hFFFFFFFF);
        for (int p = 0; p < 6; p++) begin
            apb_write(REG_WIDTH, (p == 5) ? 32'($urandom) : {16'hFFFF, widths[p]});
            for (int n = 0; n < 28; n++) begin
                if ($urandom_range(0, 15) == 0) begin
                    seg_queue.push_back(make_seg(1, $urandom, $urandom, $urandom, $urandom));
                end else begin
                    fx = rand_coord(); fy = rand_coord();
                    if ($urandom_range(0, 3) == 0)
                        seg_queue.push_back(make_seg(0, fx, fy,
                            fx + $urandom_range(0, 8) - 4, fy + $urandom_range(0, 8) - 4));
                    else
                        seg_queue.push_back(make_seg(0, fx, fy, rand_coord(), rand_coord()));
                end
            end
            drain();
        end
        // long run without flush to advance the count
        apb_write(REG_WIDTH, 32'd512);
        for (int n = 0; n < 20; n++)
            seg_queue.push_back(make_seg(0, $urandom, $urandom, $urandom, $urandom));
        drain();
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // watchdog
    initial begin
        #20ms;
        $display("tb: failure");
        $finish;
    end

endmodule
